// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions of the stable priority queue
// Storage geometry, entry and result records, operation and status codes,
// and the ring-address helpers used by the queue controller.
// ----------------------------------------------------------------------------
package spq_pkg;

	// storage geometry
	localparam int DEPTH = 16;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int VW    = 32;
	localparam int PW    = 8;
	localparam int EW    = VW + PW;

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] count_t;

	localparam count_t FULL_COUNT = count_t'(DEPTH);

	// operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	localparam logic [VW-1:0] NEG_ONE = '1;

	// one stored entry
	typedef struct packed {
		logic [PW-1:0] prio;
		logic [VW-1:0] value;
	} entry_t;

	// one result record
	typedef struct packed {
		logic [VW-1:0] removed;
		logic [1:0]    status;
		logic [VW-1:0] front;
		logic [4:0]    count;
		logic          empty;
	} res_t;

	// physical slot of logical position k behind the head
	function automatic addr_t ring_addr(input addr_t head, input addr_t k);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, k};
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// next slot round the ring
	function automatic addr_t ring_inc(input addr_t a);
		return (a == addr_t'(DEPTH - 1)) ? '0 : a + addr_t'(1);
	endfunction

	// low five bits of the entry count
	function automatic logic [4:0] count5(input count_t c);
		logic [CW+4:0] ext;
		ext = {5'b0, c};
		return ext[4:0];
	endfunction

endpackage

// ===== design/spq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted priority queue with fifo order among ties
// Entries live in a ring held in one RAM, highest priority at the head.
// ----------------------------------------------------------------------------
// Each request takes one operation at a time. A dequeue that empties the
// queue, an enqueue into an empty queue and any refused request finish in the
// cycle they are taken, and a dequeue that leaves a new front waits for the
// registered RAM read of that entry. An enqueue walks back from the tail
// through the RAM, one entry a cycle, moving each lower-priority entry up one
// slot until it meets an entry of greater or equal priority; a new entry that
// lands at the front is written at the head in a final step. The single
// RAM read port sets this pace. A result waits in an output register; while
// it is held the next request is taken, and a second finished result is
// parked until the first is collected. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stable_priority_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic signed [31:0]   value,
	input  logic [7:0]           priority_req,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   removed_value,
	output logic [1:0]           status,
	output logic signed [31:0]   front_value,
	output logic [4:0]           entry_count,
	output logic                 empty_flag
);
	import spq_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INS    = 5'b00010,
		ST_INS_WR = 5'b00100,
		ST_DEQ    = 5'b01000,
		ST_HOLD   = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	addr_t         head_q, head_d;
	count_t        count_q, count_d;
	logic [VW-1:0] front_q, front_d;
	addr_t         k_q, k_d;
	logic [VW-1:0] val_q, val_d;
	logic [PW-1:0] prio_q, prio_d;
	res_t          hold_q, res, out_q;
	logic          out_valid_q;

	logic          accept, done, out_free, load_out;
	res_t          load_res;
	logic          ram_we, ram_re;
	addr_t         ram_waddr, ram_raddr;
	entry_t        ram_wdata, rd;
	logic [EW-1:0] ram_rdata;

	spq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd       = entry_t'(ram_rdata);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// operation sequencing
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		front_d   = front_q;
		k_d       = k_q;
		val_d     = val_q;
		prio_d    = prio_q;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = entry_t'({prio_q, val_q});
		ram_re    = 1'b0;
		ram_raddr = head_q;
		done      = 1'b0;
		res       = '{removed: NEG_ONE, status: STATUS_OK, front: front_q,
			count: count5(count_q), empty: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_d  = value;
					prio_d = priority_req;
					if (operation == OP_ENQ) begin
						if (count_q == FULL_COUNT) begin
							done       = 1'b1;
							res.status = STATUS_FULL;
						end else if (count_q == '0) begin
							ram_we    = 1'b1;
							ram_waddr = head_q;
							ram_wdata = entry_t'({priority_req, value});
							front_d   = value;
							count_d   = count_t'(1);
							done      = 1'b1;
							res.front = value;
							res.count = count5(count_t'(1));
						end else begin
							k_d       = addr_t'(count_q - count_t'(1));
							ram_re    = 1'b1;
							ram_raddr = ring_addr(head_q, addr_t'(count_q - count_t'(1)));
							state_d   = ST_INS;
						end
					end else begin
						if (count_q == '0) begin
							done       = 1'b1;
							res.status = STATUS_EMPTY;
							res.front  = '0;
							res.empty  = 1'b1;
						end else if (count_q == count_t'(1)) begin
							head_d      = ring_inc(head_q);
							count_d     = '0;
							done        = 1'b1;
							res.removed = front_q;
							res.front   = '0;
							res.count   = '0;
							res.empty   = 1'b1;
						end else begin
							val_d     = front_q;
							ram_re    = 1'b1;
							ram_raddr = ring_addr(head_q, addr_t'(1));
							head_d    = ring_inc(head_q);
							count_d   = count_q - count_t'(1);
							state_d   = ST_DEQ;
						end
					end
				end
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = ring_addr(head_q, k_q + addr_t'(1));
				if (rd.prio < prio_q) begin
					// lower priority entry moves up one slot
					ram_wdata = rd;
					if (k_q == '0) begin
						state_d = ST_INS_WR;
					end else begin
						k_d       = k_q - addr_t'(1);
						ram_re    = 1'b1;
						ram_raddr = ring_addr(head_q, k_q - addr_t'(1));
					end
				end else begin
					// new entry lands behind this one
					ram_wdata = entry_t'({prio_q, val_q});
					count_d   = count_q + count_t'(1);
					done      = 1'b1;
					res.count = count5(count_q + count_t'(1));
				end
			end
			ST_INS_WR: begin
				// new entry becomes the front
				ram_we    = 1'b1;
				ram_waddr = head_q;
				ram_wdata = entry_t'({prio_q, val_q});
				front_d   = val_q;
				count_d   = count_q + count_t'(1);
				done      = 1'b1;
				res.front = val_q;
				res.count = count5(count_q + count_t'(1));
			end
			ST_DEQ: begin
				front_d     = rd.value;
				done        = 1'b1;
				res.removed = val_q;
				res.front   = rd.value;
			end
			ST_HOLD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (done) begin
			state_d = out_free ? ST_IDLE : ST_HOLD;
		end
	end

	// output register load selection
	assign load_out = (done && out_free) || (state_q == ST_HOLD && out_free);
	assign load_res = (state_q == ST_HOLD) ? hold_q : res;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		front_q <= front_d;
		k_q     <= k_d;
		val_q   <= val_d;
		prio_q  <= prio_d;
		if (done && !out_free) begin
			hold_q <= res;
		end
		if (load_out) begin
			out_q <= load_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = out_q.removed;
	assign status        = out_q.status;
	assign front_value   = out_q.front;
	assign entry_count   = out_q.count;
	assign empty_flag    = out_q.empty;

endmodule

// ===== design/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_port_checks: port-level checks of the stable priority queue
// Watches the result channel for held results and consistent status fields.
// ----------------------------------------------------------------------------
module spq_port_checks (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [31:0]  removed_value,
	input logic [1:0]          status,
	input logic signed [31:0]  front_value,
	input logic [4:0]          entry_count,
	input logic                empty_flag
);
	import spq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(removed_value)
			&& $stable(status) && $stable(front_value) && $stable(entry_count))
		else $error("result changed while stalled");

	// an empty queue reports no entries and a zero front
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_flag |-> entry_count == 5'd0 && front_value == 32'sd0)
		else $error("empty flag disagrees with count or front");

	// dequeue from empty removes nothing
	a_deq_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_EMPTY |-> removed_value == NEG_ONE && empty_flag)
		else $error("empty dequeue result malformed");

	// dropped enqueue happens only on a full queue
	a_enq_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FULL |-> removed_value == NEG_ONE && !empty_flag
			&& entry_count == count5(FULL_COUNT))
		else $error("full enqueue result malformed");

endmodule

bind stable_priority_queue spq_port_checks u_spq_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.removed_value (removed_value),
	.status        (status),
	.front_value   (front_value),
	.entry_count   (entry_count),
	.empty_flag    (empty_flag)
);

// ===== bench/spq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: result checker for the stable priority queue
// Watches both request and result channels. Each accepted request updates a
// local sorted copy of the queue, which works out the result it must cause.
// Results are compared field by field, in order, against those expectations.
// ----------------------------------------------------------------------------
module spq_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   operation,
	input  logic [spq_pkg::VW-1:0] value,
	input  logic [spq_pkg::PW-1:0] priority_req,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [spq_pkg::VW-1:0] removed_value,
	input  logic [1:0]             status,
	input  logic [spq_pkg::VW-1:0] front_value,
	input  logic [4:0]             entry_count,
	input  logic                   empty_flag,
	output int                     fail_count,
	output int                     results_waiting,
	output int                     requests_seen,
	output int                     full_drops,
	output int                     empty_pops,
	output int                     peak_fill
);
	import spq_pkg::*;

	// sorted copy of the queue, front at index 0
	logic [VW-1:0] held_value [DEPTH];
	logic [PW-1:0] held_prio  [DEPTH];
	int            fill;
	res_t          queued_results [$];

	// apply one request to the local copy and return the result it causes
	function automatic res_t predict_queue_op(input logic op, input logic [VW-1:0] v,
			input logic [PW-1:0] p);
		res_t r;
		int   pos;
		int   k;
		r.removed = NEG_ONE;
		r.status  = STATUS_OK;
		if (op == OP_ENQ) begin
			if (fill >= DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				// insert behind every entry of greater or equal priority
				pos = 0;
				while (pos < fill && held_prio[pos] >= p) begin
					pos++;
				end
				for (k = fill; k > pos; k--) begin
					held_value[k] = held_value[k-1];
					held_prio[k]  = held_prio[k-1];
				end
				held_value[pos] = v;
				held_prio[pos]  = p;
				fill++;
			end
		end else begin
			if (fill == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.removed = held_value[0];
				for (k = 1; k < fill; k++) begin
					held_value[k-1] = held_value[k];
					held_prio[k-1]  = held_prio[k];
				end
				fill--;
			end
		end
		r.front = (fill != 0) ? held_value[0] : '0;
		r.count = 5'(fill);
		r.empty = (fill == 0);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [VW-1:0] want,
			input logic [VW-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", field, want, got);
			fail_count++;
		end
	endtask

	// predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin : watch
		res_t predicted;
		res_t oldest;
		if (!arst_n) begin
			fill = 0;
			queued_results.delete();
			results_waiting <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predicted = predict_queue_op(operation, value, priority_req);
				queued_results.push_back(predicted);
				requests_seen++;
				if (predicted.status == STATUS_FULL) begin
					full_drops++;
				end
				if (predicted.status == STATUS_EMPTY) begin
					empty_pops++;
				end
				if (fill > peak_fill) begin
					peak_fill = fill;
				end
			end
			if (out_valid && out_ready) begin
				if (queued_results.size() == 0) begin
					$error("result accepted with no request outstanding");
					fail_count++;
				end else begin
					oldest = queued_results.pop_front();
					check_field("removed_value", oldest.removed, removed_value);
					check_field("status", VW'(oldest.status), VW'(status));
					check_field("front_value", oldest.front, front_value);
					check_field("entry_count", VW'(oldest.count), VW'(entry_count));
					check_field("empty_flag", VW'(oldest.empty), VW'(empty_flag));
				end
			end
			results_waiting <= queued_results.size();
		end
	end

endmodule

// ===== bench/tb_stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue: testbench top for the stable priority queue
// Drives a directed run over empty, full, tie and extreme-value cases, then
// random request mixes that swing the queue between empty and full, with
// random gaps on both channels and long result hold-offs to back up the block.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
	import spq_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int SEGMENTS       = 14;
	localparam int SEGMENT_LEN    = 50;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic                 operation    = OP_ENQ;
	logic signed [VW-1:0] value        = '0;
	logic [PW-1:0]        priority_req = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic signed [VW-1:0] removed_value;
	logic [1:0]           status;
	logic signed [VW-1:0] front_value;
	logic [4:0]           entry_count;
	logic                 empty_flag;

	int fail_count;
	int results_waiting;
	int requests_seen;
	int full_drops;
	int empty_pops;
	int peak_fill;
	int idle_cycles = 0;
	bit sender_steady = 1'b0;

	always #5 clk = ~clk;

	stable_priority_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.value         (value),
		.priority_req  (priority_req),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.removed_value (removed_value),
		.status        (status),
		.front_value   (front_value),
		.entry_count   (entry_count),
		.empty_flag    (empty_flag)
	);

	spq_checker queue_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.value           (value),
		.priority_req    (priority_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.removed_value   (removed_value),
		.status          (status),
		.front_value     (front_value),
		.entry_count     (entry_count),
		.empty_flag      (empty_flag),
		.fail_count      (fail_count),
		.results_waiting (results_waiting),
		.requests_seen   (requests_seen),
		.full_drops      (full_drops),
		.empty_pops      (empty_pops),
		.peak_fill       (peak_fill)
	);

	// offer one request after a random gap and hold it until taken
	task automatic send_request(input logic op, input logic [VW-1:0] v,
			input logic [PW-1:0] p);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		value        <= v;
		priority_req <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// reset a cycle-count watchdog on any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// result side: random gaps, steady stretches and two long hold-offs
	initial begin : drain
		int gap;
		int taken;
		bit steady;
		taken  = 0;
		steady = 1'b0;
		forever begin
			if (taken % 40 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			if (taken == 120 || taken == 450) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = steady ? 0 : $urandom_range(0, 18);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// request side
	initial begin : stimulus
		int            k;
		int            enq_pct;
		bit            narrow;
		logic          op;
		logic [PW-1:0] pr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// dequeue from an empty queue
		send_request(OP_DEQ, 32'h1357_9BDF, 8'hFF);
		// extreme values and priorities, ties at top, middle and bottom
		send_request(OP_ENQ, 32'h7FFF_FFFF, 8'd255);
		send_request(OP_ENQ, 32'h8000_0000, 8'd0);
		send_request(OP_ENQ, 32'hFFFF_FFFF, 8'd128);
		send_request(OP_ENQ, 32'h0000_0000, 8'd255);
		send_request(OP_ENQ, 32'h1234_5678, 8'd128);
		send_request(OP_ENQ, 32'hA5A5_A5A5, 8'd0);
		send_request(OP_ENQ, 32'h0000_0001, 8'd1);
		send_request(OP_ENQ, 32'h5A5A_5A5A, 8'd254);
		// fill to the brim, then one enqueue too many
		for (k = 0; k < 8; k++) begin
			send_request(OP_ENQ, 32'h0101_0101 * (k + 1), (k % 2) ? 8'd255 : 8'd128);
		end
		send_request(OP_ENQ, 32'hDEAD_BEEF, 8'd255);
		for (k = 0; k < 6; k++) begin
			send_request(OP_DEQ, $urandom, 8'($urandom));
		end

		// random mixes, each segment leaning towards filling, draining or balanced
		for (k = 0; k < SEGMENTS; k++) begin
			case ($urandom_range(0, 3))
				0: enq_pct = 15;
				1: enq_pct = 50;
				2: enq_pct = 85;
				default: enq_pct = 60;
			endcase
			narrow        = $urandom_range(0, 1);
			sender_steady = ($urandom_range(0, 3) == 0);
			repeat (SEGMENT_LEN) begin
				op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
				pr = narrow ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
				send_request(op, $urandom, pr);
			end
		end
		in_valid <= 1'b0;

		// let every outstanding result drain, then a short quiet spell
		@(posedge clk);
		while (results_waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d enqueues refused on a full queue, %0d dequeues on empty",
			requests_seen, full_drops, empty_pops);
		$display("peak occupancy %0d of %0d, result side held off twice for %0d cycles",
			peak_fill, DEPTH, HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== stable_priority_queue.f =====
design/spq_pkg.sv
design/spq_ram.sv
design/stable_priority_queue.sv
design/spq_checker.sv
bench/spq_checker.sv
bench/tb_stable_priority_queue.sv
